// ===== rtl/qrd_pkg.sv =====
// ----------------------------------------------------------------------------
// qrd_pkg
// Shared types and fixed-point helpers for the 3x3 QR decomposition pipeline.
// ----------------------------------------------------------------------------
package qrd_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic [2:0][31:0]   vec_t;
  typedef vec_t [2:0]         mat_t;
  typedef logic [2:0][63:0]   prod_t;

  localparam logic [31:0] Q_ONE = 32'h4000_0000;

  localparam logic [1:0] COL0 = 2'd0;
  localparam logic [1:0] COL1 = 2'd1;
  localparam logic [1:0] COL2 = 2'd2;

  function automatic prod_t mul3(input vec_t e, input vec_t v);
    prod_t p;
    for (int i = 0; i < 3; i++) begin
      p[i] = $signed(e[i]) * $signed(v[i]);
    end
    return p;
  endfunction

  function automatic prod_t mul_d(input logic [63:0] d, input vec_t e);
    prod_t p;
    for (int i = 0; i < 3; i++) begin
      p[i] = $signed(d[35:0]) * $signed(e[i]);
    end
    return p;
  endfunction

  function automatic logic [63:0] sum_sh(input prod_t p);
    logic signed [63:0] s;
    s = $signed(p[0]) + $signed(p[1]) + $signed(p[2]);
    return s >>> 30;
  endfunction

  function automatic logic [63:0] sub_sh(input logic [31:0] src, input logic [63:0] pr);
    logic signed [63:0] x;
    x = $signed({{32{src[31]}}, src}) - ($signed(pr) >>> 30);
    return x;
  endfunction

  function automatic logic ovf32(input logic [63:0] x);
    return ($signed(x) > 64'sd2147483647) || ($signed(x) < -64'sd2147483648);
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] x);
    logic [31:0] y;
    if ($signed(x) > 64'sd2147483647) begin
      y = 32'h7fff_ffff;
    end else if ($signed(x) < -64'sd2147483648) begin
      y = 32'h8000_0000;
    end else begin
      y = x[31:0];
    end
    return y;
  endfunction

endpackage

// ===== rtl/qrd_norm.sv =====
// ----------------------------------------------------------------------------
// qrd_norm
// Pipelined normalization of a 3-vector: squares, bit-serial root stages,
// restoring divide stages, sign restore. Side data travels with each item.
// ----------------------------------------------------------------------------
module qrd_norm #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  qrd_pkg::vec_t     in_v,
  input  logic [15:0]       thr,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output qrd_pkg::vec_t     out_e,
  output logic              out_good,
  output logic [SIDE_W-1:0] out_side
);
  import qrd_pkg::*;

  localparam int RtN = 32;
  localparam int DvN = 31;

  typedef struct packed {
    logic        below;
    logic [63:0] rem;
    logic [63:0] res;
    vec_t        v;
  } rt_t;

  typedef struct packed {
    logic             good;
    logic [31:0]      norm;
    logic [2:0][31:0] rem;
    logic [2:0]       lsb;
    logic [2:0]       neg;
    logic [2:0][30:0] quo;
  } dv_t;

  logic              sq_vld_r;
  prod_t             sq_r;
  vec_t              sq_v_r;
  logic [SIDE_W-1:0] sq_sd_r;
  logic [63:0]       len2;

  rt_t               rt_r     [RtN+1];
  logic              rt_vld_r [RtN+1];
  logic [SIDE_W-1:0] rt_sd_r  [RtN+1];

  dv_t               dv_r     [DvN+1];
  logic              dv_vld_r [DvN+1];
  logic [SIDE_W-1:0] dv_sd_r  [DvN+1];
  dv_t               dv0_nxt;

  logic              o_vld_r;
  vec_t              o_e_r;
  logic              o_good_r;
  logic [SIDE_W-1:0] o_sd_r;
  vec_t              o_e_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else if (en) begin
      sq_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r    <= mul3(in_v, in_v);
      sq_v_r  <= in_v;
      sq_sd_r <= in_side;
    end
  end

  assign len2 = sq_r[0] + sq_r[1] + sq_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_vld_r[0] <= 1'b0;
    end else if (en) begin
      rt_vld_r[0] <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt_r[0].below <= len2[63:16] < 48'(thr);
      rt_r[0].rem   <= len2;
      rt_r[0].res   <= 64'd0;
      rt_r[0].v     <= sq_v_r;
      rt_sd_r[0]    <= sq_sd_r;
    end
  end

  for (genvar k = 0; k < RtN; k++) begin : g_rt
    localparam logic [63:0] Step = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        take;
    rt_t         rt_nxt;

    always_comb begin
      trial      = rt_r[k].res + Step;
      take       = rt_r[k].rem >= trial;
      rt_nxt     = rt_r[k];
      rt_nxt.rem = take ? rt_r[k].rem - trial : rt_r[k].rem;
      rt_nxt.res = take ? (rt_r[k].res >> 1) + Step : rt_r[k].res >> 1;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        rt_vld_r[k+1] <= rt_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_r[k+1]    <= rt_nxt;
        rt_sd_r[k+1] <= rt_sd_r[k];
      end
    end
  end

  always_comb begin
    logic [31:0] m;
    dv0_nxt.good = !rt_r[RtN].below && (rt_r[RtN].res != 64'd0);
    dv0_nxt.norm = rt_r[RtN].res[31:0];
    for (int i = 0; i < 3; i++) begin
      m = rt_r[RtN].v[i][31] ? (~rt_r[RtN].v[i] + 32'd1) : rt_r[RtN].v[i];
      dv0_nxt.neg[i] = rt_r[RtN].v[i][31];
      dv0_nxt.rem[i] = {1'b0, m[31:1]};
      dv0_nxt.lsb[i] = m[0];
      dv0_nxt.quo[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= rt_vld_r[RtN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0]    <= dv0_nxt;
      dv_sd_r[0] <= rt_sd_r[RtN];
    end
  end

  for (genvar j = 0; j < DvN; j++) begin : g_dv
    dv_t dv_nxt;

    always_comb begin
      logic [32:0] wide;
      logic        ge;
      dv_nxt = dv_r[j];
      for (int i = 0; i < 3; i++) begin
        wide = {dv_r[j].rem[i], (j == 0) ? dv_r[j].lsb[i] : 1'b0};
        ge   = wide >= {1'b0, dv_r[j].norm};
        dv_nxt.rem[i] = ge ? 32'(wide - {1'b0, dv_r[j].norm}) : wide[31:0];
        dv_nxt.quo[i] = {dv_r[j].quo[i][29:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[j+1]    <= dv_nxt;
        dv_sd_r[j+1] <= dv_sd_r[j];
      end
    end
  end

  always_comb begin
    logic [31:0] q;
    for (int i = 0; i < 3; i++) begin
      q = {1'b0, dv_r[DvN].quo[i]};
      if (q > Q_ONE) begin
        q = Q_ONE;
      end
      o_e_nxt[i] = dv_r[DvN].neg[i] ? (~q + 32'd1) : q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= dv_vld_r[DvN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_e_r    <= o_e_nxt;
      o_good_r <= dv_r[DvN].good;
      o_sd_r   <= dv_sd_r[DvN];
    end
  end

  assign out_valid = o_vld_r;
  assign out_e     = o_e_r;
  assign out_good  = o_good_r;
  assign out_side  = o_sd_r;

endmodule

// ===== rtl/qr_decompose_3x3_mgs_unit.sv =====
// ----------------------------------------------------------------------------
// qr_decompose_3x3_mgs_unit
// 3x3 QR decomposition by modified Gram-Schmidt, Q16.16 in, Q2.30 / Q16.16 out.
//
//   channel  direction  handshake          payload
//   in_      input      valid / stall      nine matrix entries
//   out_     output     valid / stall      one Q column and one R column
//   cfg_     input      valid / ready      degenerate threshold
//
// A matrix can enter in any cycle the pipeline advances; the pipeline has 212
// register stages (three normalizers of 67 stages each, among them 32 root
// stages and 31 divide stages, plus 11 dot-product, hold and output stages).
// Each matrix yields three transfers on out_, so the sustained rate is set
// by the result channel.
// Synchronous active-low reset clears valid bits; threshold resets to 1.
// A stall freezes the whole pipeline; in_stall rises only while the held
// result still has columns to send.
// ----------------------------------------------------------------------------
module qr_decompose_3x3_mgs_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  qrd_pkg::word_t       in_a_r0_c0,
  input  qrd_pkg::word_t       in_a_r0_c1,
  input  qrd_pkg::word_t       in_a_r0_c2,
  input  qrd_pkg::word_t       in_a_r1_c0,
  input  qrd_pkg::word_t       in_a_r1_c1,
  input  qrd_pkg::word_t       in_a_r1_c2,
  input  qrd_pkg::word_t       in_a_r2_c0,
  input  qrd_pkg::word_t       in_a_r2_c1,
  input  qrd_pkg::word_t       in_a_r2_c2,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_column_index,
  output qrd_pkg::word_t       out_q_row0,
  output qrd_pkg::word_t       out_q_row1,
  output qrd_pkg::word_t       out_q_row2,
  output qrd_pkg::word_t       out_r_row0,
  output qrd_pkg::word_t       out_r_row1,
  output qrd_pkg::word_t       out_r_row2,
  output logic                 out_ok,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);
  import qrd_pkg::*;

  typedef struct packed {
    mat_t a;
    vec_t e0;
    vec_t t;
    vec_t r0;
    logic good;
    logic sat;
  } s2_t;

  typedef struct packed {
    vec_t        a2;
    vec_t        e0;
    vec_t        e1;
    vec_t        r0;
    logic [31:0] r11;
    logic [31:0] r12;
    logic        good;
    logic        sat;
  } s3_t;

  typedef struct packed {
    vec_t        q0;
    vec_t        q1;
    vec_t        q2;
    vec_t        r0;
    logic [31:0] r11;
    logic [31:0] r12;
    logic [31:0] r22;
    logic        ok;
  } hold_t;

  logic [15:0] thr_r;
  logic        en;
  logic        o_load;
  logic        h_take;
  logic        h_done;

  mat_t in_mat;

  logic  n1_vld;
  vec_t  n1_e;
  logic  n1_good;
  mat_t  n1_sd;

  logic          x1_vld_r;
  mat_t          x1_a_r;
  vec_t          x1_e_r;
  logic          x1_g_r;
  prod_t [2:0]   x1_p_r;

  logic          x2_vld_r;
  mat_t          x2_a_r;
  vec_t          x2_e_r;
  logic          x2_g_r;
  vec_t          x2_r0_r;
  logic          x2_sat_r;
  logic [63:0]   x2_d1_r;
  logic [63:0]   x2_d2_r;
  logic [2:0][63:0] x2_d;

  logic          x3_vld_r;
  mat_t          x3_a_r;
  vec_t          x3_e_r;
  logic          x3_g_r;
  vec_t          x3_r0_r;
  logic          x3_sat_r;
  prod_t         x3_pr1_r;
  prod_t         x3_pr2_r;

  logic          x4_vld_r;
  vec_t          x4_v_r;
  s2_t           x4_sd_r;
  vec_t          x4_v_nxt;
  s2_t           x4_sd_nxt;

  logic  n2_vld;
  vec_t  n2_e;
  logic  n2_good;
  s2_t   n2_sd;

  logic          y1_vld_r;
  s2_t           y1_sd_r;
  vec_t          y1_e_r;
  logic          y1_g_r;
  prod_t [2:0]   y1_p_r;

  logic          y2_vld_r;
  s2_t           y2_sd_r;
  vec_t          y2_e_r;
  logic          y2_g_r;
  logic [31:0]   y2_r11_r;
  logic [31:0]   y2_r12_r;
  logic [63:0]   y2_dt_r;
  logic          y2_sat_r;
  logic [63:0]   y2_s11;
  logic [63:0]   y2_s12;

  logic          y3_vld_r;
  s2_t           y3_sd_r;
  vec_t          y3_e_r;
  logic          y3_g_r;
  logic [31:0]   y3_r11_r;
  logic [31:0]   y3_r12_r;
  logic          y3_sat_r;
  prod_t         y3_pr_r;

  logic          y4_vld_r;
  vec_t          y4_v_r;
  s3_t           y4_sd_r;
  vec_t          y4_v_nxt;
  s3_t           y4_sd_nxt;

  logic  n3_vld;
  vec_t  n3_e;
  logic  n3_good;
  s3_t   n3_sd;

  logic          z1_vld_r;
  s3_t           z1_sd_r;
  vec_t          z1_e_r;
  logic          z1_g_r;
  prod_t         z1_p_r;

  logic          h_vld_r;
  hold_t         h_r;
  hold_t         h_nxt;
  logic [1:0]    col_r;

  logic          out_valid_r;
  logic [1:0]    o_col_r;
  vec_t          o_q_r;
  vec_t          o_rv_r;
  logic          o_ok_r;
  vec_t          o_q_nxt;
  vec_t          o_rv_nxt;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // flow control
  assign o_load   = !out_valid_r || !out_stall;
  assign h_take   = h_vld_r && o_load;
  assign h_done   = h_take && (col_r == COL2);
  assign en       = !h_vld_r || h_done;
  assign in_stall = !en;

  assign in_mat[0] = {in_a_r2_c0, in_a_r1_c0, in_a_r0_c0};
  assign in_mat[1] = {in_a_r2_c1, in_a_r1_c1, in_a_r0_c1};
  assign in_mat[2] = {in_a_r2_c2, in_a_r1_c2, in_a_r0_c2};

  qrd_norm #(.SIDE_W($bits(mat_t))) u_norm1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_v      (in_mat[0]),
    .thr       (thr_r),
    .in_side   (in_mat),
    .out_valid (n1_vld),
    .out_e     (n1_e),
    .out_good  (n1_good),
    .out_side  (n1_sd)
  );

  // column 0 dot products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_vld_r <= 1'b0;
      x2_vld_r <= 1'b0;
      x3_vld_r <= 1'b0;
      x4_vld_r <= 1'b0;
    end else if (en) begin
      x1_vld_r <= n1_vld;
      x2_vld_r <= x1_vld_r;
      x3_vld_r <= x2_vld_r;
      x4_vld_r <= x3_vld_r;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      x2_d[j] = sum_sh(x1_p_r[j]);
    end
  end

  always_comb begin
    logic s;
    s = x3_sat_r;
    for (int i = 0; i < 3; i++) begin
      x4_v_nxt[i]     = sat32(sub_sh(x3_a_r[1][i], x3_pr1_r[i]));
      x4_sd_nxt.t[i]  = sat32(sub_sh(x3_a_r[2][i], x3_pr2_r[i]));
      s = s | ovf32(sub_sh(x3_a_r[1][i], x3_pr1_r[i]))
            | ovf32(sub_sh(x3_a_r[2][i], x3_pr2_r[i]));
    end
    x4_sd_nxt.a    = x3_a_r;
    x4_sd_nxt.e0   = x3_e_r;
    x4_sd_nxt.r0   = x3_r0_r;
    x4_sd_nxt.good = x3_g_r;
    x4_sd_nxt.sat  = s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_a_r <= n1_sd;
      x1_e_r <= n1_e;
      x1_g_r <= n1_good;
      for (int j = 0; j < 3; j++) begin
        x1_p_r[j] <= mul3(n1_e, n1_sd[j]);
      end
      x2_a_r   <= x1_a_r;
      x2_e_r   <= x1_e_r;
      x2_g_r   <= x1_g_r;
      for (int j = 0; j < 3; j++) begin
        x2_r0_r[j] <= sat32(x2_d[j]);
      end
      x2_sat_r <= ovf32(x2_d[0]) | ovf32(x2_d[1]) | ovf32(x2_d[2]);
      x2_d1_r  <= x2_d[1];
      x2_d2_r  <= x2_d[2];
      x3_a_r   <= x2_a_r;
      x3_e_r   <= x2_e_r;
      x3_g_r   <= x2_g_r;
      x3_r0_r  <= x2_r0_r;
      x3_sat_r <= x2_sat_r;
      x3_pr1_r <= mul_d(x2_d1_r, x2_e_r);
      x3_pr2_r <= mul_d(x2_d2_r, x2_e_r);
      x4_v_r   <= x4_v_nxt;
      x4_sd_r  <= x4_sd_nxt;
    end
  end

  qrd_norm #(.SIDE_W($bits(s2_t))) u_norm2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (x4_vld_r),
    .in_v      (x4_v_r),
    .thr       (thr_r),
    .in_side   (x4_sd_r),
    .out_valid (n2_vld),
    .out_e     (n2_e),
    .out_good  (n2_good),
    .out_side  (n2_sd)
  );

  // column 1 dot products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y1_vld_r <= 1'b0;
      y2_vld_r <= 1'b0;
      y3_vld_r <= 1'b0;
      y4_vld_r <= 1'b0;
    end else if (en) begin
      y1_vld_r <= n2_vld;
      y2_vld_r <= y1_vld_r;
      y3_vld_r <= y2_vld_r;
      y4_vld_r <= y3_vld_r;
    end
  end

  assign y2_s11 = sum_sh(y1_p_r[0]);
  assign y2_s12 = sum_sh(y1_p_r[1]);

  always_comb begin
    logic s;
    s = y3_sat_r;
    for (int i = 0; i < 3; i++) begin
      y4_v_nxt[i] = sat32(sub_sh(y3_sd_r.t[i], y3_pr_r[i]));
      s = s | ovf32(sub_sh(y3_sd_r.t[i], y3_pr_r[i]));
    end
    y4_sd_nxt.a2   = y3_sd_r.a[2];
    y4_sd_nxt.e0   = y3_sd_r.e0;
    y4_sd_nxt.e1   = y3_e_r;
    y4_sd_nxt.r0   = y3_sd_r.r0;
    y4_sd_nxt.r11  = y3_r11_r;
    y4_sd_nxt.r12  = y3_r12_r;
    y4_sd_nxt.good = y3_sd_r.good & y3_g_r;
    y4_sd_nxt.sat  = s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y1_sd_r   <= n2_sd;
      y1_e_r    <= n2_e;
      y1_g_r    <= n2_good;
      y1_p_r[0] <= mul3(n2_e, n2_sd.a[1]);
      y1_p_r[1] <= mul3(n2_e, n2_sd.a[2]);
      y1_p_r[2] <= mul3(n2_e, n2_sd.t);
      y2_sd_r   <= y1_sd_r;
      y2_e_r    <= y1_e_r;
      y2_g_r    <= y1_g_r;
      y2_r11_r  <= sat32(y2_s11);
      y2_r12_r  <= sat32(y2_s12);
      y2_dt_r   <= sum_sh(y1_p_r[2]);
      y2_sat_r  <= y1_sd_r.sat | ovf32(y2_s11) | ovf32(y2_s12);
      y3_sd_r   <= y2_sd_r;
      y3_e_r    <= y2_e_r;
      y3_g_r    <= y2_g_r;
      y3_r11_r  <= y2_r11_r;
      y3_r12_r  <= y2_r12_r;
      y3_sat_r  <= y2_sat_r;
      y3_pr_r   <= mul_d(y2_dt_r, y2_e_r);
      y4_v_r    <= y4_v_nxt;
      y4_sd_r   <= y4_sd_nxt;
    end
  end

  qrd_norm #(.SIDE_W($bits(s3_t))) u_norm3 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (y4_vld_r),
    .in_v      (y4_v_r),
    .thr       (thr_r),
    .in_side   (y4_sd_r),
    .out_valid (n3_vld),
    .out_e     (n3_e),
    .out_good  (n3_good),
    .out_side  (n3_sd)
  );

  // column 2 dot product and result hold
  always_comb begin
    logic [63:0] s22;
    logic        good;
    s22  = sum_sh(z1_p_r);
    good = z1_sd_r.good & z1_g_r;
    h_nxt.ok = good & !(z1_sd_r.sat | ovf32(s22));
    if (good) begin
      h_nxt.q0  = z1_sd_r.e0;
      h_nxt.q1  = z1_sd_r.e1;
      h_nxt.q2  = z1_e_r;
      h_nxt.r0  = z1_sd_r.r0;
      h_nxt.r11 = z1_sd_r.r11;
      h_nxt.r12 = z1_sd_r.r12;
      h_nxt.r22 = sat32(s22);
    end else begin
      h_nxt.q0  = '0;
      h_nxt.q1  = '0;
      h_nxt.q2  = '0;
      h_nxt.r0  = '0;
      h_nxt.r11 = '0;
      h_nxt.r12 = '0;
      h_nxt.r22 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z1_vld_r <= 1'b0;
      h_vld_r  <= 1'b0;
    end else if (en) begin
      z1_vld_r <= n3_vld;
      h_vld_r  <= z1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1_sd_r <= n3_sd;
      z1_e_r  <= n3_e;
      z1_g_r  <= n3_good;
      z1_p_r  <= mul3(n3_e, n3_sd.a2);
      h_r     <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= COL0;
    end else if (h_take) begin
      col_r <= (col_r == COL2) ? COL0 : col_r + 2'd1;
    end
  end

  // output register
  always_comb begin
    unique case (col_r)
      COL0: begin
        o_q_nxt  = h_r.q0;
        o_rv_nxt = {32'd0, 32'd0, h_r.r0[0]};
      end
      COL1: begin
        o_q_nxt  = h_r.q1;
        o_rv_nxt = {32'd0, h_r.r11, h_r.r0[1]};
      end
      COL2: begin
        o_q_nxt  = h_r.q2;
        o_rv_nxt = {h_r.r22, h_r.r12, h_r.r0[2]};
      end
      default: begin
        o_q_nxt  = '0;
        o_rv_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_load) begin
      out_valid_r <= h_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (h_take) begin
      o_col_r <= col_r;
      o_q_r   <= o_q_nxt;
      o_rv_r  <= o_rv_nxt;
      o_ok_r  <= h_r.ok;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_column_index = o_col_r;
  assign out_q_row0       = o_q_r[0];
  assign out_q_row1       = o_q_r[1];
  assign out_q_row2       = o_q_r[2];
  assign out_r_row0       = o_rv_r[0];
  assign out_r_row1       = o_rv_r[1];
  assign out_r_row2       = o_rv_r[2];
  assign out_ok           = o_ok_r;
  assign out_last         = (o_col_r == COL2);

  a_last_col2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_column_index == COL2)
    else $error("last flag on a column other than the third");

  a_col_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !h_take |=> $stable(col_r))
    else $error("column counter moved without a transfer from hold");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> h_vld_r)
    else $error("input stalled with an empty hold stage");

  a_col0_tri: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_column_index == COL0 |-> out_r_row1 == 32'd0 && out_r_row2 == 32'd0)
    else $error("nonzero entry below the diagonal in the first R column");

endmodule
